FILE: rtl/iihc_pkg.sv
// Shared types, constants and register codes of the ignition interlock controller.
package iihc_pkg;

    localparam int TIMER_BITS = 12;
    localparam int DEB_W      = 8;
    localparam int LEVEL_W    = 16;
    localparam int DELAY_W    = 12;
    localparam int CMP_W      = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 16;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Reset values of the configuration registers
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE  = 8'd3;
    localparam logic [LEVEL_W-1:0] RST_ON_LIMIT  = 16'd21627;
    localparam logic [LEVEL_W-1:0] RST_AUTO_LIM  = 16'd43253;
    localparam logic [LEVEL_W-1:0] RST_DUSK      = 16'd19661;
    localparam logic [LEVEL_W-1:0] RST_DAYLIGHT  = 16'd39322;
    localparam logic [DELAY_W-1:0] RST_ON_DELAY  = 12'd100;
    localparam logic [DELAY_W-1:0] RST_OFF_DELAY = 12'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_ON_LIMIT  = 3'd1,
        CFG_AUTO_LIM  = 3'd2,
        CFG_DUSK      = 3'd3,
        CFG_DAYLIGHT  = 3'd4,
        CFG_ON_DELAY  = 3'd5,
        CFG_OFF_DELAY = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_ticks;
        logic [LEVEL_W-1:0] on_mode_limit;
        logic [LEVEL_W-1:0] auto_mode_limit;
        logic [LEVEL_W-1:0] dusk_level;
        logic [LEVEL_W-1:0] daylight_level;
        logic [DELAY_W-1:0] lights_on_delay;
        logic [DELAY_W-1:0] lights_off_delay;
    } cfg_t;

endpackage

FILE: rtl/iihc_debounce.sv
// Four-phase ignition button debouncer with saturating settle timer.
module iihc_debounce (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      pressed,
    input  logic [iihc_pkg::DEB_W-1:0] debounce_ticks,
    output logic                      released
);
    import iihc_pkg::*;

    typedef enum logic [1:0] {
        PH_UP   = 2'd0,
        PH_FALL = 2'd1,
        PH_DOWN = 2'd2,
        PH_RISE = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [DEB_W-1:0]  timer_reg, timer_next;
    logic [DEB_W-1:0]  timer_inc;

    assign timer_inc = (timer_reg == {DEB_W{1'b1}}) ? timer_reg : timer_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        released   = 1'b0;
        unique case (phase_reg)
            PH_UP:
            begin
                if (pressed)
                begin
                    phase_next = PH_FALL;
                    timer_next = '0;
                end
            end
            PH_FALL:
            begin
                if (timer_reg >= debounce_ticks)
                    phase_next = pressed ? PH_DOWN : PH_UP;
                timer_next = timer_inc;
            end
            PH_DOWN:
            begin
                if (!pressed)
                begin
                    phase_next = PH_RISE;
                    timer_next = '0;
                end
            end
            default:
            begin
                if (!pressed)
                begin
                    phase_next = PH_UP;
                    released   = 1'b1;
                end
                else
                    phase_next = PH_DOWN;
                timer_next = timer_inc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_UP;
            timer_reg <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
        end
    end

endmodule

FILE: rtl/iihc_beam.sv
// Headlight mode selection with dusk/daylight hysteresis and hold timers.
module iihc_beam (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        running,
    input  logic [iihc_pkg::LEVEL_W-1:0] knob_level,
    input  logic [iihc_pkg::LEVEL_W-1:0] light_level,
    input  iihc_pkg::cfg_t              cfg,
    output logic                        beam_next
);
    import iihc_pkg::*;

    logic                  beam_reg;
    logic [TIMER_BITS-1:0] dark_reg, dark_next, dark_inc;
    logic [TIMER_BITS-1:0] bright_reg, bright_next, bright_inc;

    assign dark_inc   = (dark_reg == TIMER_MAX) ? dark_reg : dark_reg + 1'b1;
    assign bright_inc = (bright_reg == TIMER_MAX) ? bright_reg : bright_reg + 1'b1;

    always_comb
    begin
        beam_next   = beam_reg;
        dark_next   = dark_reg;
        bright_next = bright_reg;
        if (!running)
            beam_next = 1'b0;
        else if (knob_level <= cfg.on_mode_limit)
            beam_next = 1'b1;
        else if (knob_level > cfg.auto_mode_limit)
            beam_next = 1'b0;
        else if (light_level <= cfg.dusk_level)
        begin
            // count darkness, switch on once the hold time is reached
            if (CMP_W'(dark_inc) >= CMP_W'(cfg.lights_on_delay))
            begin
                dark_next   = '0;
                bright_next = '0;
                beam_next   = 1'b1;
            end
            else
                dark_next = dark_inc;
        end
        else if (light_level <= cfg.daylight_level)
        begin
            dark_next   = '0;
            bright_next = '0;
        end
        else
        begin
            if (CMP_W'(bright_inc) >= CMP_W'(cfg.lights_off_delay))
            begin
                dark_next   = '0;
                bright_next = '0;
                beam_next   = 1'b0;
            end
            else
                bright_next = bright_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_reg   <= 1'b0;
            dark_reg   <= '0;
            bright_reg <= '0;
        end
        else if (en)
        begin
            beam_reg   <= beam_next;
            dark_reg   <= dark_next;
            bright_reg <= bright_next;
        end
    end

endmodule

FILE: rtl/ignition_interlock_headlight_ctrl.sv
// Top level of the ignition interlock and headlight controller.
// Data path: a tick transferred on s_* passes through the input register, then the result
// register, before it is offered on m_*. Throughput: one tick per clock;
// the held tick moves on whenever the result register is empty or drained in that cycle.
// Reset (rst_n low, asynchronous): pipeline empty, engine stopped, siren and
// beams off, timers cleared, configuration registers back to their defaults.
module ignition_interlock_headlight_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    // input tick stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] button_raw, [1] driver_seated, [2] passenger_seated,
    // [3] driver_belted, [4] passenger_belted, [20:5] knob_level,
    // [36:21] light_level, [39:37] zero
    input  logic [iihc_pkg::IN_W-1:0]       s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] ready_lamp, [1] running_lamp, [2] siren_on, [3] beams_on,
    // [4] welcome_pulse, [5] attempt_pulse, [6] start_pulse, [7] stop_pulse,
    // [11:8] missing_mask, [15:12] zero
    output logic [iihc_pkg::OUT_W-1:0]      m_tdata,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [iihc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iihc_pkg::LEVEL_W-1:0]    cfg_data
);
    import iihc_pkg::*;

    // Configuration registers
    cfg_t cfg_reg;

    // Input register (payload needs no reset)
    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;

    // Result register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    // Controller state held here; debouncer and beam logic keep their own
    logic running_reg, running_next;
    logic greeted_reg, greeted_next;
    logic siren_reg, siren_next;

    logic advance;
    logic pressed, dseat, pseat, dbelt, pbelt;
    logic [LEVEL_W-1:0] knob, light;
    logic released, all_met;
    logic ready_out, welcome, attempt, start, stop;
    logic [3:0] missing;
    logic beam_next;

    // Move the held tick into the result register when that one is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign pressed = in_data_reg[0];
    assign dseat   = in_data_reg[1];
    assign pseat   = in_data_reg[2];
    assign dbelt   = in_data_reg[3];
    assign pbelt   = in_data_reg[4];
    assign knob    = in_data_reg[20:5];
    assign light   = in_data_reg[36:21];

    assign all_met = dseat && dbelt && pseat && pbelt;

    iihc_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .pressed        (pressed),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .released       (released)
    );

    // Interlock: a release while stopped is a start attempt, while running a stop
    always_comb
    begin
        welcome      = dseat && !greeted_reg;
        greeted_next = dseat;
        running_next = running_reg;
        siren_next   = siren_reg;
        attempt      = 1'b0;
        start        = 1'b0;
        stop         = 1'b0;
        missing      = 4'd0;
        ready_out    = all_met;
        if (released && !running_reg)
        begin
            attempt = 1'b1;
            if (!all_met)
            begin
                siren_next = 1'b1;
                missing    = {!pbelt, !pseat, !dbelt, !dseat};
            end
            else
            begin
                siren_next   = 1'b0;
                ready_out    = 1'b0;
                running_next = 1'b1;
                start        = 1'b1;
            end
        end
        else if (released)
        begin
            running_next = 1'b0;
            stop         = 1'b1;
        end
    end

    iihc_beam u_beam (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .running     (running_next),
        .knob_level  (knob),
        .light_level (light),
        .cfg         (cfg_reg),
        .beam_next   (beam_next)
    );

    assign out_data_next = {4'd0, missing, stop, start, attempt, welcome,
                            beam_next, siren_next, running_next, ready_out};

    // Configuration writes: decode the index, drop unknown ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= RST_DEBOUNCE;
            cfg_reg.on_mode_limit    <= RST_ON_LIMIT;
            cfg_reg.auto_mode_limit  <= RST_AUTO_LIM;
            cfg_reg.dusk_level       <= RST_DUSK;
            cfg_reg.daylight_level   <= RST_DAYLIGHT;
            cfg_reg.lights_on_delay  <= RST_ON_DELAY;
            cfg_reg.lights_off_delay <= RST_OFF_DELAY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:  cfg_reg.debounce_ticks   <= cfg_data[DEB_W-1:0];
                CFG_ON_LIMIT:  cfg_reg.on_mode_limit    <= cfg_data;
                CFG_AUTO_LIM:  cfg_reg.auto_mode_limit  <= cfg_data;
                CFG_DUSK:      cfg_reg.dusk_level       <= cfg_data;
                CFG_DAYLIGHT:  cfg_reg.daylight_level   <= cfg_data;
                CFG_ON_DELAY:  cfg_reg.lights_on_delay  <= cfg_data[DELAY_W-1:0];
                CFG_OFF_DELAY: cfg_reg.lights_off_delay <= cfg_data[DELAY_W-1:0];
                default:       ;
            endcase
        end
    end

    // Pipeline control and interlock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            greeted_reg   <= 1'b0;
            siren_reg     <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                running_reg   <= running_next;
                greeted_reg   <= greeted_next;
                siren_reg     <= siren_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule
